// ----- hdl/ldsolve_pkg.sv -----
package ldsolve_pkg;

    localparam int DEF_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NODIV  = 2'd1,
        ST_ABZERO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_EUC = 2'd0,
        SEL_CD  = 2'd1,
        SEL_BD  = 2'd2,
        SEL_AD  = 2'd3
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EUC_GO,
        S_EUC_WAIT,
        S_MUL,
        S_UPD,
        S_CD_GO,
        S_CD_WAIT,
        S_BD_GO,
        S_BD_WAIT,
        S_AD_GO,
        S_AD_WAIT,
        S_MULK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_q;
        logic     mul;
        logic     upd;
        logic     cap_k;
        logic     cap_xs;
        logic     cap_ys;
        logic     mulk;
        logic     out_load;
        status_t  out_status;
    } cmd_t;

    typedef struct packed {
        logic ab_zero;
        logic r1_zero;
        logic div_done;
        logic rem_zero;
    } sts_t;

endpackage

// ----- hdl/ldsolve_div.sv -----
module ldsolve_div
    import ldsolve_pkg::*;
#(
    parameter int DW = DEF_WIDTH + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic signed [DW-1:0] quo,
    output logic signed [DW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, rem_reg, dmag_reg;
    logic          negq_reg, negr_reg;
    logic [DW:0]   rem_sh, diff;
    logic [DW-1:0] nmag, dmag;

    assign nmag   = num[DW-1] ? -num : num;
    assign dmag   = den[DW-1] ? -den : den;
    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, dmag_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= nmag;
            rem_reg  <= '0;
            dmag_reg <= dmag;
            negq_reg <= num[DW-1] ^ den[DW-1];
            negr_reg <= num[DW-1];
        end
        else if (busy_reg)
        begin
            // restoring step: keep the difference when it does not go negative
            if (!diff[DW])
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = negq_reg ? -quo_reg : quo_reg;
    assign rem  = negr_reg ? -rem_reg : rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

endmodule

// ----- hdl/ldsolve_dp.sv -----
module ldsolve_dp
    import ldsolve_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [WIDTH-1:0]   in_a,
    input  logic [WIDTH-1:0]   in_b,
    input  logic [WIDTH-1:0]   in_c,
    output logic [1:0]         o_status,
    output logic [WIDTH-1:0]   o_d,
    output logic [2*WIDTH-2:0] o_xp,
    output logic [2*WIDTH-2:0] o_yp,
    output logic [WIDTH-1:0]   o_xs,
    output logic [WIDTH-1:0]   o_ys
);

    localparam int DW = WIDTH + 1;
    localparam int SW = WIDTH + 3;
    localparam int PW = 2 * WIDTH - 1;

    logic signed [DW-1:0] a_reg, b_reg, c_reg;
    logic signed [DW-1:0] r0_reg, r1_reg, q_reg, rem_reg, k_reg;
    logic signed [SW-1:0] s0_reg, s1_reg, t0_reg, t1_reg, ps_reg, pt_reg;
    logic        [PW-1:0] xp_reg, yp_reg;
    logic [WIDTH-1:0]     xs_reg, ys_reg;
    logic                 remz_reg;
    logic [1:0]           ost_reg;
    logic [WIDTH-1:0]     od_reg, oxs_reg, oys_reg;
    logic [PW-1:0]        oxp_reg, oyp_reg;

    logic signed [DW-1:0]    div_num, div_quo, div_rem;
    logic                    div_busy, div_done;
    logic signed [DW+SW-1:0] ps_full, pt_full, xp_full, yp_full;

    always_comb
    begin
        case (cmd.div_sel)
            SEL_EUC: div_num = r0_reg;
            SEL_CD:  div_num = c_reg;
            SEL_BD:  div_num = b_reg;
            default: div_num = -a_reg;
        endcase
    end

    ldsolve_div #(.DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (cmd.div_sel == SEL_EUC ? r1_reg : r0_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign ps_full = q_reg * s1_reg;
    assign pt_full = q_reg * t1_reg;
    assign xp_full = s0_reg * k_reg;
    assign yp_full = t0_reg * k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg  <= DW'(signed'(in_a));
            b_reg  <= DW'(signed'(in_b));
            c_reg  <= DW'(signed'(in_c));
            r0_reg <= DW'(signed'(in_a));
            r1_reg <= DW'(signed'(in_b));
            s0_reg <= SW'(1);
            s1_reg <= '0;
            t0_reg <= '0;
            t1_reg <= SW'(1);
        end
        if (cmd.cap_q)
        begin
            q_reg   <= div_quo;
            rem_reg <= div_rem;
        end
        if (cmd.mul)
        begin
            ps_reg <= ps_full[SW-1:0];
            pt_reg <= pt_full[SW-1:0];
        end
        if (cmd.upd)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            s0_reg <= s1_reg;
            s1_reg <= s0_reg - ps_reg;
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - pt_reg;
        end
        if (cmd.cap_k)
        begin
            k_reg    <= div_quo;
            remz_reg <= (div_rem == '0);
        end
        if (cmd.cap_xs)
            xs_reg <= div_quo[WIDTH-1:0];
        if (cmd.cap_ys)
            ys_reg <= div_quo[WIDTH-1:0];
        if (cmd.mulk)
        begin
            xp_reg <= xp_full[PW-1:0];
            yp_reg <= yp_full[PW-1:0];
        end
        if (cmd.out_load)
        begin
            ost_reg <= cmd.out_status;
            od_reg  <= (cmd.out_status == ST_ABZERO) ? '0 : r0_reg[WIDTH-1:0];
            oxp_reg <= (cmd.out_status == ST_OK) ? xp_reg : '0;
            oyp_reg <= (cmd.out_status == ST_OK) ? yp_reg : '0;
            oxs_reg <= (cmd.out_status == ST_OK) ? xs_reg : '0;
            oys_reg <= (cmd.out_status == ST_OK) ? ys_reg : '0;
        end
    end

    assign sts.ab_zero  = (a_reg == '0) && (b_reg == '0);
    assign sts.r1_zero  = (r1_reg == '0);
    assign sts.div_done = div_done;
    assign sts.rem_zero = remz_reg;

    assign o_status = ost_reg;
    assign o_d      = od_reg;
    assign o_xp     = oxp_reg;
    assign o_yp     = oyp_reg;
    assign o_xs     = oxs_reg;
    assign o_ys     = oys_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("division issued while divider busy");
    a_nonzero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start && cmd.div_sel == SEL_EUC) |-> r1_reg != '0)
        else $error("Euclid step with zero remainder");
    a_cd_den: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start && cmd.div_sel != SEL_EUC) |-> r0_reg != '0)
        else $error("final division by zero");

endmodule

// ----- hdl/ldsolve_ctrl.sv -----
module ldsolve_ctrl
    import ldsolve_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    ov_reg, ov_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_CHECK;
            S_CHECK:
                if (sts.ab_zero)
                begin
                    status_next = ST_ABZERO;
                    state_next  = S_FINISH;
                end
                else if (sts.r1_zero)
                    state_next = S_CD_GO;
                else
                    state_next = S_EUC_GO;
            S_EUC_GO:
                state_next = S_EUC_WAIT;
            S_EUC_WAIT:
                if (sts.div_done)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_UPD;
            S_UPD:
                state_next = S_CHECK;
            S_CD_GO:
                state_next = S_CD_WAIT;
            S_CD_WAIT:
                if (sts.div_done)
                    state_next = S_BD_GO;
            S_BD_GO:
                // k and the remainder of c / d are in place now
                if (!sts.rem_zero)
                begin
                    status_next = ST_NODIV;
                    state_next  = S_FINISH;
                end
                else
                    state_next = S_BD_WAIT;
            S_BD_WAIT:
                if (sts.div_done)
                    state_next = S_AD_GO;
            S_AD_GO:
                state_next = S_AD_WAIT;
            S_AD_WAIT:
                if (sts.div_done)
                    state_next = S_MULK;
            S_MULK:
            begin
                status_next = ST_OK;
                state_next  = S_FINISH;
            end
            S_FINISH:
                if (!ov_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = SEL_EUC;
        cmd.out_status = status_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_EUC_GO:
                cmd.div_start = 1'b1;
            S_EUC_WAIT:
                cmd.cap_q = sts.div_done;
            S_MUL:
                cmd.mul = 1'b1;
            S_UPD:
                cmd.upd = 1'b1;
            S_CD_GO:
            begin
                cmd.div_sel   = SEL_CD;
                cmd.div_start = 1'b1;
            end
            S_CD_WAIT:
            begin
                cmd.div_sel = SEL_CD;
                cmd.cap_k   = sts.div_done;
            end
            S_BD_GO:
            begin
                cmd.div_sel   = SEL_BD;
                cmd.div_start = sts.rem_zero;
            end
            S_BD_WAIT:
            begin
                cmd.div_sel = SEL_BD;
                cmd.cap_xs  = sts.div_done;
            end
            S_AD_GO:
            begin
                cmd.div_sel   = SEL_AD;
                cmd.div_start = 1'b1;
            end
            S_AD_WAIT:
            begin
                cmd.div_sel = SEL_AD;
                cmd.cap_ys  = sts.div_done;
            end
            S_MULK:
                cmd.mulk = 1'b1;
            S_FINISH:
                cmd.out_load = !ov_reg || m_tready;
            default:
                cmd.load = 1'b0;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_load)
            ov_next = 1'b1;
        else if (m_tready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            ov_reg     <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!ov_reg || m_tready))
        else $error("result register overwritten before transfer");
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == S_CHECK)
        else $error("accepted transaction not processed");
    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_EUC_WAIT || state_reg == S_CD_WAIT
                          || state_reg == S_BD_WAIT || state_reg == S_AD_WAIT))
        else $error("division finished outside a wait state");

endmodule

// ----- hdl/linear_diophantine_solver.sv -----
// Run time grows with the number of Euclid iterations, each one a divider run, plus the final
// divisions c / d, b / d and -a / d; with b = 0 the Euclid loop is skipped.
// a = b = 0 and d not dividing c finish early; a held result stalls the final load.
// Throughput: one transaction at a time, set by the shared bit-serial divider.
// A finished result sits in the output register while the next transaction runs.
// Reset: rst_n asynchronous, active low; clears control state and drops m_tvalid.
module linear_diophantine_solver
    import ldsolve_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coef_a, coef_b, rhs_c
    input  logic [((3*WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // divisor_d, x_particular, y_particular, x_step, y_step
    output logic [((7*WIDTH-2+7)/8)*8-1:0]      m_tdata,
    // status
    output logic [1:0]                          m_tuser
);

    localparam int OTW = ((7 * WIDTH - 2 + 7) / 8) * 8;

    cmd_t cmd;
    sts_t sts;
    logic [WIDTH-1:0]   o_d, o_xs, o_ys;
    logic [2*WIDTH-2:0] o_xp, o_yp;

    ldsolve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ldsolve_dp #(.WIDTH(WIDTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_a     (s_tdata[WIDTH-1:0]),
        .in_b     (s_tdata[2*WIDTH-1:WIDTH]),
        .in_c     (s_tdata[3*WIDTH-1:2*WIDTH]),
        .o_status (m_tuser),
        .o_d      (o_d),
        .o_xp     (o_xp),
        .o_yp     (o_yp),
        .o_xs     (o_xs),
        .o_ys     (o_ys)
    );

    assign m_tdata = OTW'({o_ys, o_xs, o_yp, o_xp, o_d});

endmodule
